// ===== design/chd_pkg.sv =====
// shared constants, stage schedule, pipeline payload type and the square-root step helper for the direction sampler
package chd_pkg;

   localparam int FIELD_W      = 16;
   localparam int FRAC_BITS    = 14;
   localparam int RAND_BITS    = 16;
   localparam int WORK_FRAC    = 30;
   localparam int CORDIC_STEPS = 30;
   localparam int SQRT_STEPS   = 32;
   localparam int DIV_STEPS    = 31;

   // reciprocal of the cordic gain in q30
   localparam logic [33:0] CORDIC_GAIN = 34'd652032874;

   // arctangent of 2^-i in units of 2^-32 turn
   localparam logic [31:0] ATAN_TURN [CORDIC_STEPS] = '{
      32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
      32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
      32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
      32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
      32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
      32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001
   };

   // stage schedule
   localparam int ST_PREP    = 0;
   localparam int ST_CORDIC0 = ST_PREP + 1;
   localparam int ST_QUAD    = ST_CORDIC0 + CORDIC_STEPS;
   localparam int ST_SQRT0   = ST_PREP + 1;
   localparam int ST_LEN     = ST_PREP + 1;
   localparam int ST_LSQRT0  = ST_LEN + 1;
   localparam int ST_MUL     = ST_LSQRT0 + SQRT_STEPS - 1;
   localparam int ST_DIVINIT = ST_MUL + 1;
   localparam int ST_DIV0    = ST_DIVINIT + 1;
   localparam int ST_SIGN    = ST_DIV0 + DIV_STEPS;
   localparam int ST_CROSS   = ST_SIGN + 1;
   localparam int ST_BITAN   = ST_CROSS + 1;
   localparam int ST_PROD    = ST_BITAN + 1;
   localparam int ST_SUM     = ST_PROD + 1;
   localparam int ST_OUT     = ST_SUM + 1;
   localparam int NUM_STAGES = ST_OUT + 1;

   typedef struct packed {
      logic [2:0][FIELD_W-1:0] n;
      logic [2:0][FIELD_W-1:0] t;
      logic [FIELD_W-1:0]      u1;
      logic [FIELD_W-1:0]      u2;
      logic                    zero;
      logic [33:0]             cx;
      logic [33:0]             cy;
      logic [32:0]             cz;
      logic [1:0]              quad;
      logic [31:0]             c;
      logic [31:0]             s;
      logic [63:0]             r1v;
      logic [63:0]             r1r;
      logic [63:0]             szv;
      logic [63:0]             szr;
      logic [63:0]             lv;
      logic [63:0]             lr;
      logic [63:0]             pc;
      logic [63:0]             ps;
      logic [31:0]             sx;
      logic [31:0]             sy;
      logic [31:0]             lq;
      logic [2:0][61:0]        dd;
      logic [2:0][32:0]        rem;
      logic [2:0][30:0]        quo;
      logic [2:0][31:0]        ex;
      logic [5:0][47:0]        cp;
      logic [2:0][31:0]        ey;
      logic [8:0][63:0]        fp;
      logic [2:0][63:0]        acc;
      logic [2:0][FIELD_W-1:0] dir;
   } pipe_type;

   typedef struct packed {
      logic [63:0] v;
      logic [63:0] r;
   } sqrt_type;

   // one step of the bit-pair integer square root
   function automatic sqrt_type sqrt_step(sqrt_type a, logic [63:0] b);
      sqrt_type o;
      if (a.v >= a.r + b) begin
         o.v = a.v - (a.r + b);
         o.r = (a.r >> 1) + b;
      end else begin
         o.v = a.v;
         o.r = a.r >> 1;
      end
      return o;
   endfunction

endpackage

// ===== design/chd_stage.sv =====
// one register stage of the sampler pipeline with its own slice of the datapath
module chd_stage
   import chd_pkg::*;
#(
   parameter int STAGE = 0
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     in_valid,
   input  pipe_type in_data,
   output logic     in_ready,
   output logic     out_valid,
   output pipe_type out_data,
   input  logic     out_ready
);

   localparam int CI = (STAGE >= ST_CORDIC0 && STAGE < ST_QUAD) ? STAGE - ST_CORDIC0 : 0;
   localparam int SI = (STAGE >= ST_SQRT0 && STAGE < ST_SQRT0 + SQRT_STEPS) ?
                       STAGE - ST_SQRT0 : 0;
   localparam int LI = (STAGE >= ST_LSQRT0 && STAGE < ST_LSQRT0 + SQRT_STEPS) ?
                       STAGE - ST_LSQRT0 : 0;
   localparam int DI = (STAGE >= ST_DIV0 && STAGE < ST_SIGN) ? STAGE - ST_DIV0 : 0;
   localparam logic signed [15:0] ONE = 16'(1 << FRAC_BITS);

   logic     valid_ff, valid_in;
   pipe_type data_ff, data_in;

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   always_comb begin
      logic signed [15:0] nc [3];
      logic        [15:0] mg [3];
      logic        [31:0] ang;
      logic signed [33:0] x, y, nx, ny;
      logic signed [32:0] z;
      sqrt_type           sq;
      logic signed [31:0] tsq [3];
      logic        [31:0] len;
      logic signed [63:0] pw;
      logic        [61:0] dv;
      logic        [32:0] r2;
      logic signed [48:0] df;
      logic signed [63:0] dr;
      logic signed [32:0] szs;
      data_in  = in_data;
      valid_in = in_valid;
      nc  = '{default: '0};
      mg  = '{default: '0};
      tsq = '{default: '0};
      ang = '0;
      x = '0; y = '0; nx = '0; ny = '0; z = '0;
      sq = '0; len = '0; pw = '0; dv = '0; r2 = '0; df = '0; dr = '0; szs = '0;

      if (STAGE == ST_PREP) begin
         for (int k = 0; k < 3; k++) begin
            if ($signed(in_data.n[k]) > ONE) nc[k] = ONE;
            else if ($signed(in_data.n[k]) < -ONE) nc[k] = -ONE;
            else nc[k] = $signed(in_data.n[k]);
            mg[k] = (nc[k] < 0) ? 16'(-nc[k]) : 16'(nc[k]);
            data_in.n[k] = nc[k];
         end
         // smallest magnitude is zeroed, ties favor x then y
         if (mg[0] <= mg[1] && mg[0] <= mg[2]) begin
            data_in.t[0] = '0;
            data_in.t[1] = nc[2];
            data_in.t[2] = -nc[1];
         end else if (mg[1] <= mg[2]) begin
            data_in.t[0] = nc[2];
            data_in.t[1] = '0;
            data_in.t[2] = -nc[0];
         end else begin
            data_in.t[0] = nc[1];
            data_in.t[1] = -nc[0];
            data_in.t[2] = '0;
         end
         ang = 32'(in_data.u1[RAND_BITS-1:0]) << (32 - RAND_BITS);
         data_in.cx   = CORDIC_GAIN;
         data_in.cy   = '0;
         data_in.cz   = {3'b000, ang[29:0]};
         data_in.quad = ang[31:30];
         data_in.r1v  = 64'(17'(1 << RAND_BITS) - 17'(in_data.u2[RAND_BITS-1:0]))
                        << (60 - RAND_BITS);
         data_in.szv  = 64'(in_data.u2[RAND_BITS-1:0]) << (60 - RAND_BITS);
         data_in.r1r  = '0;
         data_in.szr  = '0;
      end

      if (STAGE >= ST_CORDIC0 && STAGE < ST_QUAD) begin
         x = $signed(in_data.cx);
         y = $signed(in_data.cy);
         z = $signed(in_data.cz);
         if (z >= 0) begin
            nx = x - (y >>> CI);
            ny = y + (x >>> CI);
            z  = z - $signed({1'b0, ATAN_TURN[CI]});
         end else begin
            nx = x + (y >>> CI);
            ny = y - (x >>> CI);
            z  = z + $signed({1'b0, ATAN_TURN[CI]});
         end
         data_in.cx = nx;
         data_in.cy = ny;
         data_in.cz = z;
      end

      if (STAGE == ST_QUAD) begin
         x = $signed(in_data.cx);
         y = $signed(in_data.cy);
         case (in_data.quad)
            2'd0: begin
               data_in.c = 32'(x);
               data_in.s = 32'(y);
            end
            2'd1: begin
               data_in.c = 32'(-y);
               data_in.s = 32'(x);
            end
            2'd2: begin
               data_in.c = 32'(-x);
               data_in.s = 32'(-y);
            end
            default: begin
               data_in.c = 32'(y);
               data_in.s = 32'(-x);
            end
         endcase
      end

      if (STAGE >= ST_SQRT0 && STAGE < ST_SQRT0 + SQRT_STEPS) begin
         sq = sqrt_step({in_data.r1v, in_data.r1r}, 64'(1) << (62 - 2 * SI));
         data_in.r1v = sq.v;
         data_in.r1r = sq.r;
         sq = sqrt_step({in_data.szv, in_data.szr}, 64'(1) << (62 - 2 * SI));
         data_in.szv = sq.v;
         data_in.szr = sq.r;
      end

      if (STAGE == ST_LEN) begin
         for (int k = 0; k < 3; k++)
            tsq[k] = $signed(in_data.t[k]) * $signed(in_data.t[k]);
         len = 32'(tsq[0] + tsq[1] + tsq[2]);
         data_in.zero = (len == '0);
         data_in.lv   = 64'(len) << 32;
         data_in.lr   = '0;
      end

      if (STAGE >= ST_LSQRT0 && STAGE < ST_LSQRT0 + SQRT_STEPS) begin
         sq = sqrt_step({in_data.lv, in_data.lr}, 64'(1) << (62 - 2 * LI));
         data_in.lv = sq.v;
         data_in.lr = sq.r;
      end

      if (STAGE == ST_MUL) begin
         pw = $signed(in_data.c) * $signed({1'b0, in_data.r1r[31:0]});
         data_in.pc = pw;
         pw = $signed(in_data.s) * $signed({1'b0, in_data.r1r[31:0]});
         data_in.ps = pw;
      end

      if (STAGE == ST_DIVINIT) begin
         pw = ($signed(in_data.pc) + 64'sd536870912) >>> WORK_FRAC;
         data_in.sx = pw[31:0];
         pw = ($signed(in_data.ps) + 64'sd536870912) >>> WORK_FRAC;
         data_in.sy = pw[31:0];
         data_in.lq = in_data.lr[31:0];
         for (int k = 0; k < 3; k++) begin
            mg[k] = ($signed(in_data.t[k]) < 0) ? 16'(-$signed(in_data.t[k])) : in_data.t[k];
            // rounded quotient: add half the divisor to the dividend
            dv = (62'(mg[k]) << (60 - FRAC_BITS)) + 62'(in_data.lr[31:1]);
            data_in.dd[k]  = dv;
            data_in.rem[k] = 33'(dv[61:31]);
            data_in.quo[k] = '0;
         end
      end

      if (STAGE >= ST_DIV0 && STAGE < ST_SIGN) begin
         for (int k = 0; k < 3; k++) begin
            r2 = {in_data.rem[k][31:0], in_data.dd[k][30 - DI]};
            if (r2 >= {1'b0, in_data.lq}) begin
               data_in.rem[k] = r2 - {1'b0, in_data.lq};
               data_in.quo[k] = {in_data.quo[k][29:0], 1'b1};
            end else begin
               data_in.rem[k] = r2;
               data_in.quo[k] = {in_data.quo[k][29:0], 1'b0};
            end
         end
      end

      if (STAGE == ST_SIGN) begin
         for (int k = 0; k < 3; k++)
            data_in.ex[k] = ($signed(in_data.t[k]) < 0) ? -{1'b0, in_data.quo[k]}
                                                         : {1'b0, in_data.quo[k]};
      end

      if (STAGE == ST_CROSS) begin
         data_in.cp[0] = $signed(in_data.n[1]) * $signed(in_data.ex[2]);
         data_in.cp[1] = $signed(in_data.n[2]) * $signed(in_data.ex[1]);
         data_in.cp[2] = $signed(in_data.n[2]) * $signed(in_data.ex[0]);
         data_in.cp[3] = $signed(in_data.n[0]) * $signed(in_data.ex[2]);
         data_in.cp[4] = $signed(in_data.n[0]) * $signed(in_data.ex[1]);
         data_in.cp[5] = $signed(in_data.n[1]) * $signed(in_data.ex[0]);
      end

      if (STAGE == ST_BITAN) begin
         for (int k = 0; k < 3; k++) begin
            df = $signed({in_data.cp[2*k][47], in_data.cp[2*k]})
                 - $signed({in_data.cp[2*k+1][47], in_data.cp[2*k+1]});
            df = (df + (49'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
            data_in.ey[k] = df[31:0];
         end
      end

      if (STAGE == ST_PROD) begin
         szs = $signed({1'b0, in_data.szr[31:0]});
         for (int k = 0; k < 3; k++) begin
            pw = $signed(in_data.sx) * $signed(in_data.ex[k]);
            data_in.fp[3*k] = pw;
            pw = $signed(in_data.sy) * $signed(in_data.ey[k]);
            data_in.fp[3*k+1] = pw;
            pw = szs * $signed(in_data.n[k]);
            data_in.fp[3*k+2] = pw;
         end
      end

      if (STAGE == ST_SUM) begin
         for (int k = 0; k < 3; k++)
            data_in.acc[k] = $signed(in_data.fp[3*k]) + $signed(in_data.fp[3*k+1])
                             + ($signed(in_data.fp[3*k+2]) <<< (WORK_FRAC - FRAC_BITS));
      end

      if (STAGE == ST_OUT) begin
         for (int k = 0; k < 3; k++) begin
            dr = ($signed(in_data.acc[k]) + (64'sd1 <<< (2*WORK_FRAC - FRAC_BITS - 1)))
                 >>> (2*WORK_FRAC - FRAC_BITS);
            if (in_data.zero) data_in.dir[k] = '0;
            else if (dr > 64'(ONE)) data_in.dir[k] = ONE;
            else if (dr < -64'(ONE)) data_in.dir[k] = -ONE;
            else data_in.dir[k] = dr[15:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

endmodule

// ===== design/cosine_hemisphere_direction.sv =====
// top level of the cosine-weighted hemisphere direction sampler
// Usage: present a unit normal (q1.14) and two uniform fractions (q0.16) on the req_ channel;
// one direction (q1.14, saturated) per beat comes back on the rsp_ channel, in order.
// Both channels are valid/ready. The block is a linear pipeline of 72 registered stages:
// prep, 30 cordic rotations, the two sample square roots (32 bit-pair steps each), the
// tangent-length square root, 31 restoring-division steps for the tangent, then cross
// product, rotation products, sum and rounding.
// rsp_valid rises once the accepted req_ beat has passed through every stage register.
// Throughput: one beat per cycle while rsp_ready holds no stall; every stage holds one item
// and the longest stage is one 32x32 multiply or one 64-bit add and compare.
// Each stage has its own valid bit and advances when empty or when the next stage moves,
// so bubbles are squeezed out and a stalled rsp_ready fills the pipe before req_ready drops.
// Reset clears all valid bits; no beat is in flight afterward and no clearing pass is needed.
// A stall loses or repeats nothing: a stage only loads when it is empty or its successor takes its item.
module cosine_hemisphere_direction
   import chd_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic signed [FIELD_W-1:0] req_normal_x,
   input  logic signed [FIELD_W-1:0] req_normal_y,
   input  logic signed [FIELD_W-1:0] req_normal_z,
   input  logic        [FIELD_W-1:0] req_rand_angle,
   input  logic        [FIELD_W-1:0] req_rand_radius,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic signed [FIELD_W-1:0] rsp_dir_x,
   output logic signed [FIELD_W-1:0] rsp_dir_y,
   output logic signed [FIELD_W-1:0] rsp_dir_z
);

   pipe_type stage_data  [NUM_STAGES+1];
   logic     stage_valid [NUM_STAGES+1];
   logic     stage_ready [NUM_STAGES+1];

   always_comb begin
      stage_data[0]      = '0;
      stage_data[0].n[0] = req_normal_x;
      stage_data[0].n[1] = req_normal_y;
      stage_data[0].n[2] = req_normal_z;
      stage_data[0].u1   = req_rand_angle;
      stage_data[0].u2   = req_rand_radius;
   end

   assign stage_valid[0] = req_valid;
   assign req_ready      = stage_ready[0];

   for (genvar g = 0; g < NUM_STAGES; g++) begin : g_stage
      chd_stage #(
         .STAGE(g)
      ) u_stage (
         .clock    (clock),
         .reset    (reset),
         .in_valid (stage_valid[g]),
         .in_data  (stage_data[g]),
         .in_ready (stage_ready[g]),
         .out_valid(stage_valid[g+1]),
         .out_data (stage_data[g+1]),
         .out_ready(stage_ready[g+1])
      );
   end

   assign stage_ready[NUM_STAGES] = rsp_ready;
   assign rsp_valid = stage_valid[NUM_STAGES];
   assign rsp_dir_x = stage_data[NUM_STAGES].dir[0];
   assign rsp_dir_y = stage_data[NUM_STAGES].dir[1];
   assign rsp_dir_z = stage_data[NUM_STAGES].dir[2];

endmodule
